>>> sv/pll_divider_search_unit_defines.svh
// Assertion macros shared by the checker files of the PLL divider search unit.
// Depends on nothing; a file that uses them has clk and arst_n in scope.
`ifndef PLL_DIVIDER_SEARCH_UNIT_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_UNIT_DEFINES_SVH

// A property that must hold at every rising edge outside reset.
`define PDS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An expression that must never be true outside reset.
`define PDS_NEVER(lbl, expr, msg) \
	`PDS_CHECK(lbl, !(expr), msg)

`endif

>>> sv/pds_pkg.sv
// Package of the PLL divider search unit: widths, constants, preset table,
// state, command and status types. Depends on nothing.
`default_nettype none

package pds_pkg;

	localparam int REFDIV_LIMIT   = 63;
	localparam int PRESET_ENTRIES = 7;
	localparam int TABLE_SIZE     = 7;
	localparam int PRESET_USED    = (PRESET_ENTRIES < TABLE_SIZE) ? PRESET_ENTRIES : TABLE_SIZE;

	localparam int DIV_W     = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// The reference divider counter must reach REFDIV_LIMIT itself, at most 127.
	localparam int R_W     = 7;
	localparam int KHZ_W   = 23;
	localparam int P1_W    = 20;
	localparam int P2_W    = 17;
	localparam int PP_W    = 6;
	localparam int VCO_W   = 29;
	localparam int SV_W    = 22;
	localparam int FREF_W  = 15;
	localparam int FB_W    = 12;
	localparam int RD_W    = 6;
	localparam int PD_W    = 3;
	localparam int ST_W    = 3;

	localparam int HZ_PER_KHZ = 1000;
	localparam int REF_KHZ    = 24000;
	localparam int VCO_LOW    = 800000;
	localparam int VCO_HIGH   = 3200000;
	localparam int FB_MAX     = 3200;
	localparam int FB_MIN     = 16;
	localparam int POST_MAX   = 7;
	localparam int MISS_LIMIT = 4000;

	// Hz to kHz is floor(hz * KHZ_RECIP / 2^KHZ_SHIFT), exact for every 32-bit rate.
	localparam int              KHZ_SHIFT = 38;
	localparam logic [28:0]     KHZ_RECIP = 29'd274877907;

	localparam logic [ST_W-1:0] ST_PRESET = 3'd0;
	localparam logic [ST_W-1:0] ST_OK     = 3'd1;
	localparam logic [ST_W-1:0] ST_LOW    = 3'd2;
	localparam logic [ST_W-1:0] ST_NOVCO  = 3'd3;
	localparam logic [ST_W-1:0] ST_MISS   = 3'd4;

	typedef struct packed {
		logic [31:0]     hz;
		logic [RD_W-1:0] refdiv;
		logic [FB_W-1:0] fbdiv;
		logic [PD_W-1:0] post1;
		logic [PD_W-1:0] post2;
	} preset_t;

	localparam preset_t PRESETS [TABLE_SIZE] = '{
		'{32'd1200000000, 6'd1,  12'd50,  3'd1, 3'd1},
		'{32'd1188000000, 6'd2,  12'd99,  3'd1, 3'd1},
		'{32'd1100000000, 6'd12, 12'd550, 3'd1, 3'd1},
		'{32'd1008000000, 6'd1,  12'd84,  3'd2, 3'd1},
		'{32'd1000000000, 6'd6,  12'd500, 3'd2, 3'd1},
		'{32'd816000000,  6'd1,  12'd68,  3'd2, 3'd1},
		'{32'd600000000,  6'd1,  12'd75,  3'd3, 3'd1}
	};

	typedef enum logic [4:0] {
		S_IDLE, S_PRESET, S_CHK_KHZ, S_W_P1, S_CHK_P1, S_CHK_P2,
		S_W_P1B, S_PP, S_VCO, S_CHK_VCO, S_LOOP, S_W_FREF, S_FB, S_W_FB, S_FINISH, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_SAVE_KHZ, OP_DIV_P1, OP_SAVE_P1,
		OP_SAVE_P2, OP_DIV_P1B, OP_SAVE_P1B, OP_MUL_PP, OP_MUL_VCO, OP_INIT,
		OP_DIV_FREF, OP_DIV_FB, OP_EVAL
	} op_t;

	typedef enum logic [2:0] {
		RES_PRESET, RES_OK, RES_LOW, RES_NOVCO, RES_MISS
	} res_t;

	typedef struct packed {
		op_t  op;
		logic out_wr;
		res_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic preset_hit;
		logic khz_zero;
		logic p1_big;
		logic p2_big;
		logic vco_bad;
		logic div_done;
		logic search_done;
		logic miss;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> sv/pds_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pds_pkg for its width.
`default_nettype none

module pds_divider
	import pds_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  done,
	output logic      [DIV_W-1:0] quot,
	output logic      [DIV_W-1:0] rem
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_W-1:0]     quot_q, rem_q, dvs_q;
	logic [DIV_W:0]       shifted;
	logic                 fits;

	assign shifted = {rem_q, quot_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(DIV_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (cnt_q != '0) begin
			quot_q <= {quot_q[DIV_W-2:0], fits};
			rem_q  <= fits ? DIV_W'(shifted - {1'b0, dvs_q}) : shifted[DIV_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

>>> sv/pds_datapath.sv
// Datapath of the PLL divider search: working registers, the shared divider,
// candidate evaluation and the result register. Depends on pds_pkg, pds_divider.
`default_nettype none

module pds_datapath
	import pds_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dp_cmd_t         cmd,
	input  wire logic [31:0]     requested_hz,
	output dp_stat_t             stat,
	output logic [ST_W-1:0]      status,
	output logic [RD_W-1:0]      ref_divider,
	output logic [FB_W-1:0]      feedback_divider,
	output logic [PD_W-1:0]      post_divider_one,
	output logic [PD_W-1:0]      post_divider_two
);

	logic [31:0]      hz_q;
	logic [KHZ_W-1:0] khz_q;
	logic [P1_W-1:0]  p1_q;
	logic [P2_W-1:0]  p2_q;
	logic [PP_W-1:0]  pp_q;
	logic [VCO_W-1:0] vco_q;
	logic [FREF_W-1:0] fref_q;
	logic [SV_W-1:0]  best_q;
	logic [R_W-1:0]   r_q;
	logic [RD_W-1:0]  best_r_q;
	logic [FB_W-1:0]  best_f_q;

	logic [ST_W-1:0] st_q;
	logic [RD_W-1:0] rd_q;
	logic [FB_W-1:0] fd_q;
	logic [PD_W-1:0] pd1_q, pd2_q;

	logic             div_start, div_done;
	logic [DIV_W-1:0] div_a, div_b, div_quot, div_rem;

	logic    hit;
	preset_t hit_entry;

	logic [60:0]      khz_prod;
	logic [P2_W-1:0]  p2_calc;

	// First preset whose rate matches wins.
	always_comb begin
		hit       = 1'b0;
		hit_entry = PRESETS[0];
		for (int i = PRESET_USED - 1; i >= 0; i--) begin
			if (PRESETS[i].hz == hz_q) begin
				hit       = 1'b1;
				hit_entry = PRESETS[i];
			end
		end
	end

	// The kHz rate comes from a reciprocal multiplication.
	assign khz_prod = {29'd0, hz_q} * {32'd0, KHZ_RECIP};

	// Post divider two is ceil(p1 / 7); any value past seven only has to read as too big.
	always_comb begin
		p2_calc = P2_W'(POST_MAX + 1);
		for (int k = POST_MAX; k >= 1; k--) begin
			if (p1_q <= P1_W'(k * POST_MAX)) begin
				p2_calc = P2_W'(k);
			end
		end
	end

	always_comb begin
		div_start = 1'b1;
		div_a     = '0;
		div_b     = DIV_W'(1);
		case (cmd.op)
			OP_DIV_P1: begin
				div_a = DIV_W'(VCO_LOW - 1) + DIV_W'(khz_q);
				div_b = DIV_W'(khz_q);
			end
			OP_DIV_P1B: begin
				div_a = DIV_W'(p1_q) + DIV_W'(p2_q) - DIV_W'(1);
				div_b = DIV_W'(p2_q);
			end
			OP_DIV_FREF: begin
				div_a = DIV_W'(REF_KHZ);
				div_b = DIV_W'(r_q);
			end
			OP_DIV_FB: begin
				div_a = DIV_W'(vco_q[SV_W-1:0]);
				div_b = DIV_W'(fref_q);
			end
			default: div_start = 1'b0;
		endcase
	end

	pds_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Candidate for the current reference divider: quotient and remainder of vco / fref.
	logic [FB_W-1:0]   fb, cand_f;
	logic [FREF_W-1:0] diff, cand_d;
	logic              fb_ok, round_up, better;

	always_comb begin
		fb       = div_quot[FB_W-1:0];
		diff     = div_rem[FREF_W-1:0];
		fb_ok    = (div_quot < DIV_W'(FB_MAX)) && (div_quot > DIV_W'(FB_MIN));
		round_up = (fb < FB_W'(FB_MAX - 1)) && (diff > (fref_q >> 1));
		cand_f   = round_up ? fb + 1'b1 : fb;
		cand_d   = round_up ? fref_q - diff : diff;
		better   = fb_ok && (SV_W'(cand_d) < best_q);
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				hz_q <= requested_hz;
				p2_q <= P2_W'(1);
			end
			OP_SAVE_KHZ: khz_q  <= khz_prod[KHZ_SHIFT +: KHZ_W];
			OP_SAVE_P1:  p1_q   <= div_quot[P1_W-1:0];
			OP_SAVE_P2:  p2_q   <= p2_calc;
			OP_SAVE_P1B: p1_q   <= div_quot[P1_W-1:0];
			OP_MUL_PP:   pp_q   <= p1_q[PD_W-1:0] * p2_q[PD_W-1:0];
			OP_MUL_VCO:  vco_q  <= VCO_W'(khz_q) * VCO_W'(pp_q);
			OP_INIT: begin
				best_q   <= vco_q[SV_W-1:0];
				r_q      <= R_W'(1);
				best_r_q <= '0;
				best_f_q <= '0;
			end
			OP_EVAL: begin
				r_q <= r_q + 1'b1;
				if (better) begin
					best_q   <= SV_W'(cand_d);
					best_r_q <= r_q[RD_W-1:0];
					best_f_q <= cand_f;
				end
			end
			default: ;
		endcase
	end

	// The reference frequency is captured when its division completes.
	logic fref_pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fref_pending_q <= 1'b0;
		end else if (cmd.op == OP_DIV_FREF) begin
			fref_pending_q <= 1'b1;
		end else if (div_done) begin
			fref_pending_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fref_pending_q && div_done) begin
			fref_q <= div_quot[FREF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_wr) begin
			rd_q  <= '0;
			fd_q  <= '0;
			pd1_q <= '0;
			pd2_q <= '0;
			case (cmd.kind)
				RES_PRESET: begin
					st_q  <= ST_PRESET;
					rd_q  <= hit_entry.refdiv;
					fd_q  <= hit_entry.fbdiv;
					pd1_q <= hit_entry.post1;
					pd2_q <= hit_entry.post2;
				end
				RES_OK: begin
					st_q  <= ST_OK;
					rd_q  <= best_r_q;
					fd_q  <= best_f_q;
					pd1_q <= p1_q[PD_W-1:0];
					pd2_q <= p2_q[PD_W-1:0];
				end
				RES_LOW:   st_q <= ST_LOW;
				RES_NOVCO: st_q <= ST_NOVCO;
				default:   st_q <= ST_MISS;
			endcase
		end
	end

	always_comb begin
		stat.preset_hit  = hit;
		stat.khz_zero    = (khz_q == '0);
		stat.p1_big      = (p1_q > P1_W'(POST_MAX));
		stat.p2_big      = (p2_q > P2_W'(POST_MAX));
		stat.vco_bad     = (vco_q < VCO_W'(VCO_LOW)) || (vco_q > VCO_W'(VCO_HIGH));
		stat.div_done    = div_done;
		stat.search_done = (r_q >= R_W'(REFDIV_LIMIT)) || (best_q == '0);
		stat.miss        = (best_q > SV_W'(MISS_LIMIT)) || (best_r_q == '0);
	end

	assign status           = st_q;
	assign ref_divider      = rd_q;
	assign feedback_divider = fd_q;
	assign post_divider_one = pd1_q;
	assign post_divider_two = pd2_q;

endmodule

`default_nettype wire

>>> sv/pds_ctrl.sv
// Controller of the PLL divider search: sequences the datapath and owns
// both handshakes. Depends on pds_pkg.
`default_nettype none

module pds_ctrl
	import pds_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t state_q, state_d;
	res_t   res_q, res_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= RES_MISS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.out_wr) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		res_d      = res_q;
		cmd.op     = OP_NONE;
		cmd.out_wr = 1'b0;
		cmd.kind   = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_PRESET;
				end
			end
			S_PRESET: begin
				if (stat.preset_hit) begin
					res_d   = RES_PRESET;
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_SAVE_KHZ;
					state_d = S_CHK_KHZ;
				end
			end
			S_CHK_KHZ: begin
				if (stat.khz_zero) begin
					res_d   = RES_LOW;
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_DIV_P1;
					state_d = S_W_P1;
				end
			end
			S_W_P1: begin
				if (stat.div_done) begin
					cmd.op  = OP_SAVE_P1;
					state_d = S_CHK_P1;
				end
			end
			S_CHK_P1: begin
				if (stat.p1_big) begin
					cmd.op  = OP_SAVE_P2;
					state_d = S_CHK_P2;
				end else begin
					state_d = S_PP;
				end
			end
			S_CHK_P2: begin
				if (stat.p2_big) begin
					res_d   = RES_NOVCO;
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_DIV_P1B;
					state_d = S_W_P1B;
				end
			end
			S_W_P1B: begin
				if (stat.div_done) begin
					cmd.op  = OP_SAVE_P1B;
					state_d = S_PP;
				end
			end
			S_PP: begin
				cmd.op  = OP_MUL_PP;
				state_d = S_VCO;
			end
			S_VCO: begin
				cmd.op  = OP_MUL_VCO;
				state_d = S_CHK_VCO;
			end
			S_CHK_VCO: begin
				if (stat.vco_bad) begin
					res_d   = RES_NOVCO;
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_INIT;
					state_d = S_LOOP;
				end
			end
			S_LOOP: begin
				if (stat.search_done) begin
					state_d = S_FINISH;
				end else begin
					cmd.op  = OP_DIV_FREF;
					state_d = S_W_FREF;
				end
			end
			S_W_FREF: begin
				if (stat.div_done) begin
					state_d = S_FB;
				end
			end
			S_FB: begin
				cmd.op  = OP_DIV_FB;
				state_d = S_W_FB;
			end
			S_W_FB: begin
				if (stat.div_done) begin
					cmd.op  = OP_EVAL;
					state_d = S_LOOP;
				end
			end
			S_FINISH: begin
				res_d   = stat.miss ? RES_MISS : RES_OK;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_wr = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> sv/pll_divider_search_unit.sv
// Top level of the PLL divider search unit: controller plus datapath.
// Depends on pds_pkg, pds_ctrl, pds_datapath.
//
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_stall   requested_hz
// result    out        out_valid / out_stall status, ref_divider, feedback_divider,
//                                            post_divider_one, post_divider_two
//
// A preset match goes from S_PRESET straight to S_OUT, with no division.
// The kHz rate and the second post divider come from a multiplication and a
// compare. Every other division runs on one shared 32-bit divider at one
// quotient bit per cycle; the post-divider phase takes one or two of them, and
// each reference divider tried takes two; a full search tries 62 of them.
// Reset is asynchronous and active low; no item is in flight after it.
// One item is worked at a time; the next is taken as soon as the result sits in
// the output register, even if the consumer is still stalling it.
`default_nettype none

module pll_divider_search_unit
	import pds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [31:0]       requested_hz,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [ST_W-1:0]        status,
	output logic [RD_W-1:0]        ref_divider,
	output logic [FB_W-1:0]        feedback_divider,
	output logic [PD_W-1:0]        post_divider_one,
	output logic [PD_W-1:0]        post_divider_two
);

	// The controller issues one command per cycle; the datapath reports flags.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	pds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pds_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.requested_hz     (requested_hz),
		.stat             (stat),
		.status           (status),
		.ref_divider      (ref_divider),
		.feedback_divider (feedback_divider),
		.post_divider_one (post_divider_one),
		.post_divider_two (post_divider_two)
	);

endmodule

`default_nettype wire

>>> sv/pds_checker.sv
// Port-level checks of the PLL divider search unit, bound to the top level.
// Depends on pds_pkg and pll_divider_search_unit_defines.svh.
`default_nettype none
`include "pll_divider_search_unit_defines.svh"

module pds_checker
	import pds_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [31:0]       requested_hz,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [ST_W-1:0]   status,
	input wire logic [RD_W-1:0]   ref_divider,
	input wire logic [FB_W-1:0]   feedback_divider,
	input wire logic [PD_W-1:0]   post_divider_one,
	input wire logic [PD_W-1:0]   post_divider_two
);

	`PDS_CHECK(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "no busy after accept")
	`PDS_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(feedback_divider), "stalled result changed")
	`PDS_NEVER(a_status_range, out_valid && status > ST_MISS, "status code out of range")
	`PDS_NEVER(a_err_zero, out_valid && (status == ST_LOW || status == ST_NOVCO || status == ST_MISS) && (ref_divider != '0 || feedback_divider != '0 || post_divider_one != '0 || post_divider_two != '0), "error result with dividers")
	`PDS_NEVER(a_ok_range, out_valid && status == ST_OK && (ref_divider == '0 || feedback_divider <= FB_W'(FB_MIN) || feedback_divider >= FB_W'(FB_MAX) || post_divider_one == '0 || post_divider_two == '0), "search result out of range")

endmodule

bind pll_divider_search_unit pds_checker u_pds_checker (.*);

`default_nettype wire

>>> test/tb_pds_checker.sv
`timescale 1ns / 1ps
// Checker for the PLL divider search unit: watches both channels, predicts each
// result from the requested rate and compares it. Depends on pds_pkg.
`default_nettype none

module tb_pds_checker
	import pds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [31:0]       requested_hz,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [ST_W-1:0]   status,
	input  wire logic [RD_W-1:0]   ref_divider,
	input  wire logic [FB_W-1:0]   feedback_divider,
	input  wire logic [PD_W-1:0]   post_divider_one,
	input  wire logic [PD_W-1:0]   post_divider_two,
	output int                     fail_count,
	output int                     pending
);

	typedef struct packed {
		logic [ST_W-1:0] st;
		logic [RD_W-1:0] rd;
		logic [FB_W-1:0] fb;
		logic [PD_W-1:0] p1;
		logic [PD_W-1:0] p2;
	} divider_set_t;

	divider_set_t expected_dividers[$];

	function automatic divider_set_t search_dividers(input logic [31:0] hz);
		divider_set_t res;
		longint unsigned khz, p1, p2, vco, best, best_r, best_f, fref, fb, diff;
		res = '0;
		for (int i = 0; i < PRESET_USED; i++) begin
			if (PRESETS[i].hz == hz) begin
				res.st = ST_PRESET;
				res.rd = PRESETS[i].refdiv;
				res.fb = PRESETS[i].fbdiv;
				res.p1 = PRESETS[i].post1;
				res.p2 = PRESETS[i].post2;
				return res;
			end
		end
		khz = hz / HZ_PER_KHZ;
		if (khz == 0) begin
			res.st = ST_LOW;
			return res;
		end
		p2 = 1;
		p1 = (VCO_LOW + khz - 1) / khz;
		if (p1 > POST_MAX) begin
			p2 = (p1 + POST_MAX - 1) / POST_MAX;
			p1 = (p1 + p2 - 1) / p2;
		end
		vco = khz * p1 * p2;
		if (vco < VCO_LOW || vco > VCO_HIGH || p2 > POST_MAX) begin
			res.st = ST_NOVCO;
			return res;
		end
		best = vco;
		best_r = 0;
		best_f = 0;
		for (int r = 1; r < REFDIV_LIMIT && best != 0; r++) begin
			fref = REF_KHZ / r;
			fb = vco / fref;
			if (fb >= FB_MAX || fb <= FB_MIN)
				continue;
			diff = vco - fb * fref;
			if (fb + 1 < FB_MAX && diff > fref / 2) begin
				fb++;
				diff = fref - diff;
			end
			if (diff >= best)
				continue;
			best = diff;
			best_r = r;
			best_f = fb;
		end
		if (best > MISS_LIMIT || best_r == 0) begin
			res.st = ST_MISS;
			return res;
		end
		res.st = ST_OK;
		res.rd = RD_W'(best_r);
		res.fb = FB_W'(best_f);
		res.p1 = PD_W'(p1);
		res.p2 = PD_W'(p2);
		return res;
	endfunction

	assign pending = expected_dividers.size();

	always @(posedge clk or negedge arst_n) begin
		divider_set_t want, got;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_dividers.push_back(search_dividers(requested_hz));
			if (out_valid && !out_stall) begin
				got = {status, ref_divider, feedback_divider,
					post_divider_one, post_divider_two};
				if (expected_dividers.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_dividers.pop_front();
					if (want !== got) begin
						$display("%0t: mismatch expected st=%0d rd=%0d fb=%0d p1=%0d p2=%0d",
							$time, want.st, want.rd, want.fb, want.p1, want.p2);
						$display("%0t:          actual   st=%0d rd=%0d fb=%0d p1=%0d p2=%0d",
							$time, got.st, got.rd, got.fb, got.p1, got.p2);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Top of the PLL divider search testbench: clock, reset, request stimulus,
// result stalls and verdict. Depends on pds_pkg, tb_pds_checker and the block.
`default_nettype none

module tb_top;
	import pds_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [31:0]       requested_hz = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ST_W-1:0]   status;
	logic [RD_W-1:0]   ref_divider;
	logic [FB_W-1:0]   feedback_divider;
	logic [PD_W-1:0]   post_divider_one;
	logic [PD_W-1:0]   post_divider_two;
	int                fail_count;
	int                pending;

	// Random stalls are suppressed while calm_phase is set, and the receiver
	// holds off entirely while hold_results is set.
	logic calm_phase = 1'b0;
	logic hold_results = 1'b0;

	always #10 clk = ~clk;

	pll_divider_search_unit u_top (.*);

	tb_pds_checker u_checker (.*);

	// The receiver stalls at random, with a chance of 19 percent, except in the calm
	// phase, and stalls solidly during the long hold-off.
	always @(posedge clk) begin
		if (hold_results)
			out_stall <= 1'b1;
		else if (calm_phase)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 19);
	end

	// Picks a rate. Most fall near the useful band so that the search really
	// runs; the rest cover presets, tiny rates and arbitrary words.
	function automatic logic [31:0] pick_rate();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return PRESETS[$urandom_range(TABLE_SIZE - 1)].hz;
		if (sel < 15)
			return $urandom_range(1999);
		if (sel < 25)
			return $urandom;
		if (sel < 40)
			return $urandom_range(32'd99_999_999, 32'd1000);
		if (sel < 50)
			return 1000 * $urandom_range(3_300_000, 800_000);
		return $urandom_range(32'd3_300_000_000, 32'd100_000_000);
	endfunction

	// Offers one item and holds it steady until the block takes it. When
	// the next item follows at once, valid simply stays high.
	task automatic send_rate(input logic [31:0] hz, input bit may_idle);
		if (may_idle && !calm_phase)
			while ($urandom_range(99) < 19) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		requested_hz <= hz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	logic [31:0] directed_rates[] = '{
		32'd0, 32'd1, 32'd999, 32'd1000, 32'd1999,
		32'd1200000000, 32'd1188000000, 32'd1100000000, 32'd1008000000,
		32'd1000000000, 32'd816000000, 32'd600000000,
		32'd1200000001, 32'd800000000, 32'd3200000000, 32'd3200001000,
		32'd114285000, 32'd16326000, 32'd16327000, 32'd12345678,
		32'd400000000, 32'd1234567000, 32'hFFFFFFFF, 32'h80000000, 32'h55555555
	};

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rates[i])
			send_rate(directed_rates[i], 1'b1);
		go_idle();

		// The sender pauses until every outstanding result has come back.
		while (pending != 0)
			@(posedge clk);

		// Long receiver hold-off while the sender keeps offering items, so the
		// output register fills and the block stalls its input.
		fork
			begin
				hold_results <= 1'b1;
				repeat (400) @(posedge clk);
				hold_results <= 1'b0;
			end
			for (int k = 0; k < 6; k++)
				send_rate(PRESETS[k].hz, 1'b0);
		join
		go_idle();

		for (int n = 0; n < 300; n++) begin
			calm_phase <= (n >= 120 && n < 160);
			send_rate(pick_rate(), 1'b1);
		end
		calm_phase <= 1'b0;
		go_idle();

		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// The timeout allows for the worst case over some 330 items.
	initial begin
		#100_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

>>> pll_divider_search_unit.f
+incdir+sv
sv/pds_pkg.sv
sv/pds_divider.sv
sv/pds_datapath.sv
sv/pds_ctrl.sv
sv/pll_divider_search_unit.sv
sv/pds_checker.sv
test/tb_pds_checker.sv
test/tb_top.sv
